/* rtl/nearest_k_objects_rotated_defines.svh */
// Assertion macros shared by the RTL of nearest_k_objects_rotated.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef NEAREST_K_OBJECTS_ROTATED_DEFINES_SVH
`define NEAREST_K_OBJECTS_ROTATED_DEFINES_SVH

// Property checked on every clock edge outside reset
`define NKOR_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next
`define NKOR_CHECK_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* rtl/nkor_pkg.sv */
// Shared types and constants for the nearest-object selector.
// No dependencies; imported by nkor_cell, nkor_sqrt and the top level.
package nkor_pkg;

    // Field widths
    localparam int POS_W     = 32;   // signed 16.16 positions
    localparam int TRIG_W    = 16;   // signed Q2.14 cos/sin
    localparam int REL_W     = 34;   // signed 18.16 rotated offsets
    localparam int DIST_W    = 33;   // unsigned 17.16 distance
    localparam int RAD_W     = 68;   // square-root radicand
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_TERM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_TERM = 2'd3;

    // One kept object
    typedef struct packed {
        logic                     valid;
        logic signed [REL_W-1:0]  forward;
        logic signed [REL_W-1:0]  side;
        logic [DIST_W-1:0]        distance;
    } slot_t;

    // Commands broadcast to the chain of slot cells
    typedef struct packed {
        logic insert;   // place the broadcast object by distance
        logic shift;    // move every slot one place toward the head
    } cell_ctrl_t;

    localparam slot_t SLOT_EMPTY = '0;

endpackage

/* rtl/nkor_cell.sv */
// One slot of the sorted store: holds one object and trades with its neighbors.
// Depends on nkor_pkg.
module nkor_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nkor_pkg::cell_ctrl_t ctrl,
    input  nkor_pkg::slot_t      new_slot,     // object being inserted
    input  nkor_pkg::slot_t      prev_slot,    // neighbor nearer the head
    input  logic                 prev_beaten,
    input  nkor_pkg::slot_t      next_slot,    // neighbor farther from the head
    output nkor_pkg::slot_t      slot,
    output logic                 beaten
);
    import nkor_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [REL_W-1:0]  forward_reg;
    logic signed [REL_W-1:0]  forward_next;
    logic signed [REL_W-1:0]  side_reg;
    logic signed [REL_W-1:0]  side_next;
    logic [DIST_W-1:0]        distance_reg;
    logic [DIST_W-1:0]        distance_next;
    slot_t                    load;
    logic                     do_load;

    // New object goes ahead of this slot; equal distance keeps the older one
    assign beaten = !valid_reg || (new_slot.distance < distance_reg);

    // Choose what this slot takes this cycle
    always_comb
    begin
        load    = new_slot;
        do_load = 1'b0;
        if (ctrl.shift)
        begin
            load    = next_slot;
            do_load = 1'b1;
        end
        else if (ctrl.insert && beaten)
        begin
            load    = prev_beaten ? prev_slot : new_slot;
            do_load = 1'b1;
        end
        valid_next    = do_load ? load.valid    : valid_reg;
        forward_next  = do_load ? load.forward  : forward_reg;
        side_next     = do_load ? load.side     : side_reg;
        distance_next = do_load ? load.distance : distance_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        forward_reg  <= forward_next;
        side_reg     <= side_next;
        distance_reg <= distance_next;
    end

    assign slot = '{valid: valid_reg, forward: forward_reg, side: side_reg,
                    distance: distance_reg};

endmodule

/* rtl/nkor_sqrt.sv */
// Bit-serial square root, one result bit per cycle, rounded to nearest.
// Depends on nkor_pkg.
module nkor_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nkor_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [nkor_pkg::DIST_W-1:0] root
);
    import nkor_pkg::*;

    localparam int STEPS  = RAD_W / 2;
    localparam int ROOT_W = STEPS;
    localparam int REM_W  = ROOT_W + 4;
    localparam int CNT_W  = $clog2(STEPS);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;
    logic                 fits;
    logic                 last_step;
    logic                 round_up;
    logic [ROOT_W:0]      root_rnd;

    // One digit step of the restoring root
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;
    assign last_step = cnt_reg == CNT_W'(STEPS - 1);

    // Control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    // Round to nearest, saturate to the output width
    assign round_up = rem_reg > {4'b0000, root_reg};
    assign root_rnd = {1'b0, root_reg} + (ROOT_W + 1)'(round_up);
    assign root     = (|root_rnd[ROOT_W:DIST_W]) ? '1 : root_rnd[DIST_W-1:0];
    assign done     = done_reg;

endmodule

/* rtl/nearest_k_objects_rotated.sv */
// Keeps the KEEP_COUNT nearest of the first MAX_OBJECTS eligible objects of a
// scan, rotated into the viewer frame, and lists them nearest first on the
// end-of-scan item. Items are taken one at a time. An eligible object passes
// through the shared 33x33 multiplier (six products plus accumulate), a
// rounding state that also starts the root and the bit-serial square root (34
// digit steps) before the sequencer is back in idle and the next item can be
// taken. An item that is not stored leaves the sequencer idle unless it ends
// the scan. The end-of-scan item then sends KEEP_COUNT results, one per output
// transfer, and the store is empty afterward.
// Depends on nkor_pkg, nkor_cell, nkor_sqrt and the assertion macro header.
`include "nearest_k_objects_rotated_defines.svh"

module nearest_k_objects_rotated #(
    parameter int KEEP_COUNT  = 3,
    parameter int MAX_OBJECTS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [nkor_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nkor_pkg::CFG_W-1:0]           cfg_data,
    // objects in
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [nkor_pkg::POS_W-1:0]    obj_x,
    input  logic signed [nkor_pkg::POS_W-1:0]    obj_y,
    input  logic                                 eligible,
    input  logic                                 end_of_scan,
    // results out
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [nkor_pkg::REL_W-1:0]    rel_forward,
    output logic signed [nkor_pkg::REL_W-1:0]    rel_side,
    output logic [nkor_pkg::DIST_W-1:0]          distance,
    output logic                                 present,
    output logic                                 last_result
);
    import nkor_pkg::*;

    localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
    localparam int EMIT_W = $clog2(KEEP_COUNT + 1);
    localparam int OFF_W  = POS_W + 1;
    localparam int PROD_W = 2 * OFF_W;
    localparam int ACC_W  = 50;
    localparam int SQ_W   = 65;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Multiplier schedule
    localparam logic [2:0] STEP_DX_COS = 3'd0;
    localparam logic [2:0] STEP_DY_SIN = 3'd1;
    localparam logic [2:0] STEP_DY_COS = 3'd2;
    localparam logic [2:0] STEP_DX_SIN = 3'd3;
    localparam logic [2:0] STEP_DX_DX  = 3'd4;
    localparam logic [2:0] STEP_DY_DY  = 3'd5;
    localparam logic [2:0] STEP_END    = 3'd6;

    // Rounds a Q.14 sum half up and saturates to 34 bits signed
    function automatic logic signed [REL_W-1:0] round_sat(input logic signed [ACC_W-1:0] sum);
        logic signed [ACC_W:0] biased;
        logic signed [36:0]    quo;
        logic signed [REL_W-1:0] res;
        biased = (ACC_W + 1)'(sum) + (ACC_W + 1)'(8192);
        quo    = 37'(biased >>> 14);
        if (quo[36:33] == 4'b0000 || quo[36:33] == 4'b1111)
            res = quo[REL_W-1:0];
        else if (quo[36])
            res = {1'b1, {(REL_W-1){1'b0}}};
        else
            res = {1'b0, {(REL_W-1){1'b1}}};
        return res;
    endfunction

    // Configuration registers
    logic signed [POS_W-1:0]  viewer_x_reg;
    logic signed [POS_W-1:0]  viewer_y_reg;
    logic signed [TRIG_W-1:0] cos_term_reg;
    logic signed [TRIG_W-1:0] sin_term_reg;

    // Control
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [2:0]         step_reg;
    logic [2:0]         step_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [EMIT_W-1:0]  emit_cnt_reg;
    logic [EMIT_W-1:0]  emit_cnt_next;
    logic               prod_vld_reg;
    logic               prod_vld_next;

    // Datapath
    logic signed [OFF_W-1:0]  dx_reg;
    logic signed [OFF_W-1:0]  dy_reg;
    logic                     end_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]               prod_step_reg;
    logic signed [ACC_W-1:0]  fwd_acc_reg;
    logic signed [ACC_W-1:0]  side_acc_reg;
    logic [SQ_W-1:0]          sq_acc_reg;
    logic signed [REL_W-1:0]  fwd_reg;
    logic signed [REL_W-1:0]  side_reg;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     take;
    logic                     emit_last;
    logic signed [OFF_W-1:0]  op_a;
    logic signed [OFF_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [ACC_W-1:0]  prod_acc;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [DIST_W-1:0]        sqrt_root;

    cell_ctrl_t               cell_ctrl;
    slot_t                    new_slot;
    slot_t                    cell_slot [KEEP_COUNT];
    logic [KEEP_COUNT-1:0]    beaten_vec;
    logic [KEEP_COUNT-1:0]    valid_vec;
    slot_t                    head;

    // Handshake
    assign in_stall  = state_reg != ST_IDLE;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = state_reg == ST_EMIT;
    assign out_xfer  = out_valid && !out_stall;
    assign take      = eligible && (count_reg < CNT_W'(MAX_OBJECTS));
    assign emit_last = emit_cnt_reg == EMIT_W'(KEEP_COUNT - 1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg <= '0;
            viewer_y_reg <= '0;
            cos_term_reg <= TRIG_W'(16384);
            sin_term_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIEWER_X: viewer_x_reg <= cfg_data;
                REG_VIEWER_Y: viewer_y_reg <= cfg_data;
                REG_COS_TERM: cos_term_reg <= cfg_data[TRIG_W-1:0];
                REG_SIN_TERM: sin_term_reg <= cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        emit_cnt_next = '0;
        prod_vld_next = (state_reg == ST_MUL) && (step_reg != STEP_END);
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_DX_COS;
                if (in_xfer)
                begin
                    if (take)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_MUL;
                    end
                    else if (end_of_scan)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_END)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                    state_next = end_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                emit_cnt_next = emit_cnt_reg;
                if (out_xfer)
                begin
                    emit_cnt_next = emit_cnt_reg + EMIT_W'(1);
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // the scan count restarts with the results
        if (state_next == ST_EMIT)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_DX_COS;
            count_reg    <= '0;
            emit_cnt_reg <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            emit_cnt_reg <= emit_cnt_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        unique case (step_reg)
            STEP_DX_COS: begin op_a = dx_reg; op_b = OFF_W'(cos_term_reg); end
            STEP_DY_SIN: begin op_a = dy_reg; op_b = OFF_W'(sin_term_reg); end
            STEP_DY_COS: begin op_a = dy_reg; op_b = OFF_W'(cos_term_reg); end
            STEP_DX_SIN: begin op_a = dx_reg; op_b = OFF_W'(sin_term_reg); end
            STEP_DX_DX:  begin op_a = dx_reg; op_b = dx_reg;               end
            STEP_DY_DY:  begin op_a = dy_reg; op_b = dy_reg;               end
            default:     begin op_a = dx_reg; op_b = dy_reg;               end
        endcase
    end

    assign prod_full = op_a * op_b;
    assign prod_acc  = prod_reg[ACC_W-1:0];

    // Offsets, products and sums
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dx_reg       <= OFF_W'(obj_x) - OFF_W'(viewer_x_reg);
            dy_reg       <= OFF_W'(obj_y) - OFF_W'(viewer_y_reg);
            end_reg      <= end_of_scan;
            fwd_acc_reg  <= '0;
            side_acc_reg <= '0;
            sq_acc_reg   <= '0;
        end
        else if (prod_vld_reg)
        begin
            case (prod_step_reg)
                STEP_DX_COS, STEP_DY_SIN: fwd_acc_reg  <= fwd_acc_reg + prod_acc;
                STEP_DY_COS:              side_acc_reg <= side_acc_reg + prod_acc;
                STEP_DX_SIN:              side_acc_reg <= side_acc_reg - prod_acc;
                default:                  sq_acc_reg   <= sq_acc_reg + {1'b0, prod_reg[SQ_W-2:0]};
            endcase
        end
        if (prod_vld_next)
        begin
            prod_reg      <= prod_full;
            prod_step_reg <= step_reg;
        end
        if (state_reg == ST_ROUND)
        begin
            fwd_reg  <= round_sat(fwd_acc_reg);
            side_reg <= round_sat(side_acc_reg);
        end
    end

    // Distance
    assign sqrt_start = state_reg == ST_ROUND;

    nkor_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({{(RAD_W - SQ_W){1'b0}}, sq_acc_reg}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Chain of sorted slots, head is the nearest
    assign cell_ctrl.insert = (state_reg == ST_SQRT) && sqrt_done;
    assign cell_ctrl.shift  = out_xfer;
    assign new_slot = '{valid: 1'b1, forward: fwd_reg, side: side_reg, distance: sqrt_root};

    for (genvar k = 0; k < KEEP_COUNT; k++)
    begin : g_cell
        slot_t prev_s;
        slot_t next_s;
        logic  prev_b;

        if (k == 0)
        begin : g_head
            assign prev_s = SLOT_EMPTY;
            assign prev_b = 1'b0;
        end
        else
        begin : g_body
            assign prev_s = cell_slot[k-1];
            assign prev_b = beaten_vec[k-1];
        end

        if (k == KEEP_COUNT - 1)
        begin : g_tail
            assign next_s = SLOT_EMPTY;
        end
        else
        begin : g_mid
            assign next_s = cell_slot[k+1];
        end

        nkor_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .new_slot    (new_slot),
            .prev_slot   (prev_s),
            .prev_beaten (prev_b),
            .next_slot   (next_s),
            .slot        (cell_slot[k]),
            .beaten      (beaten_vec[k])
        );

        assign valid_vec[k] = cell_slot[k].valid;
    end

    // Results come from the head slot, which holds while stalled
    assign head        = cell_slot[0];
    assign present     = head.valid;
    assign rel_forward = head.valid ? head.forward  : '0;
    assign rel_side    = head.valid ? head.side     : '0;
    assign distance    = head.valid ? head.distance : '0;
    assign last_result = emit_last;

    // Checks
    `NKOR_CHECK(a_valid_packed, (valid_vec & (valid_vec + KEEP_COUNT'(1))) == '0, "slot valid bits not packed at the head")
    `NKOR_CHECK(a_done_in_sqrt, !sqrt_done || state_reg == ST_SQRT, "root finished outside the distance phase")
    `NKOR_CHECK_NEXT(a_empty_after, out_xfer && last_result, valid_vec == '0, "store not empty after the final result")
    `NKOR_CHECK_NEXT(a_emit_start, in_xfer && !take && end_of_scan, out_valid && emit_cnt_reg == '0, "results did not start for an unstored end item")

    for (genvar k = 1; k < KEEP_COUNT; k++)
    begin : g_sorted
        `NKOR_CHECK(a_sorted, !valid_vec[k] || cell_slot[k-1].distance <= cell_slot[k].distance, "slots out of distance order")
    end

endmodule
